// ===== rtl/i2bd_pkg.sv =====
// Shared types, constants and the control-store program of the base-digit converter.
`timescale 1ns / 1ps

package i2bd_pkg;

	localparam int VALUE_BITS_DEF = 31;
	localparam int BASE_BITS_DEF  = 16;

	localparam int PC_W = 4;

	// Datapath operations, one per control word.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_PUSH,
		OP_READ,
		OP_EMIT_DIGIT,
		OP_EMIT_CONST
	} op_t;

	// Branch conditions the sequencer can test.
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_IN_VALID,
		C_BAD_OR_ZERO,
		C_CNT_LAST,
		C_QUO_ZERO,
		C_OUT_FREE,
		C_STACK_EMPTY
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic            gated;  // operation runs only when the condition holds
		logic [PC_W-1:0] jt;     // next step when the condition holds
		logic [PC_W-1:0] jf;     // next step otherwise
	} ucode_t;

	typedef struct packed {
		op_t  op;
		logic en;
	} ctrl_t;

	typedef struct packed {
		logic bad_or_zero;
		logic cnt_last;
		logic quo_zero;
		logic stack_empty;
		logic out_free;
	} status_t;

	// Program step addresses.
	localparam logic [PC_W-1:0] PC_IDLE     = PC_W'(0);
	localparam logic [PC_W-1:0] PC_CHECK    = PC_W'(1);
	localparam logic [PC_W-1:0] PC_DIV_INIT = PC_W'(2);
	localparam logic [PC_W-1:0] PC_DIV_STEP = PC_W'(3);
	localparam logic [PC_W-1:0] PC_PUSH     = PC_W'(4);
	localparam logic [PC_W-1:0] PC_READ     = PC_W'(5);
	localparam logic [PC_W-1:0] PC_EMIT     = PC_W'(6);
	localparam logic [PC_W-1:0] PC_NEXT     = PC_W'(7);
	localparam logic [PC_W-1:0] PC_KEMIT    = PC_W'(8);

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			PC_IDLE:     w = '{OP_LOAD,       C_IN_VALID,    1'b1, PC_CHECK,    PC_IDLE};
			PC_CHECK:    w = '{OP_NONE,       C_BAD_OR_ZERO, 1'b0, PC_KEMIT,    PC_DIV_INIT};
			PC_DIV_INIT: w = '{OP_DIV_INIT,   C_ALWAYS,      1'b0, PC_DIV_STEP, PC_DIV_STEP};
			PC_DIV_STEP: w = '{OP_DIV_STEP,   C_CNT_LAST,    1'b0, PC_PUSH,     PC_DIV_STEP};
			PC_PUSH:     w = '{OP_PUSH,       C_QUO_ZERO,    1'b0, PC_READ,     PC_DIV_INIT};
			PC_READ:     w = '{OP_READ,       C_ALWAYS,      1'b0, PC_EMIT,     PC_EMIT};
			PC_EMIT:     w = '{OP_EMIT_DIGIT, C_OUT_FREE,    1'b1, PC_NEXT,     PC_EMIT};
			PC_NEXT:     w = '{OP_NONE,       C_STACK_EMPTY, 1'b0, PC_IDLE,     PC_READ};
			PC_KEMIT:    w = '{OP_EMIT_CONST, C_OUT_FREE,    1'b1, PC_IDLE,     PC_KEMIT};
			default:     w = '{OP_NONE,       C_ALWAYS,      1'b0, PC_IDLE,     PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/i2bd_seq.sv =====
// Microcode sequencer: step counter, control store and branch logic.
`timescale 1ns / 1ps

module i2bd_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  i2bd_pkg::status_t status,
	output i2bd_pkg::ctrl_t   ctrl
);
	import i2bd_pkg::*;

	logic [PC_W-1:0] pc_q;
	ucode_t          cw;
	logic            cond_true;

	assign cw = ucode_rom(pc_q);

	always_comb begin
		unique case (cw.cond)
			C_ALWAYS:      cond_true = 1'b1;
			C_IN_VALID:    cond_true = in_valid;
			C_BAD_OR_ZERO: cond_true = status.bad_or_zero;
			C_CNT_LAST:    cond_true = status.cnt_last;
			C_QUO_ZERO:    cond_true = status.quo_zero;
			C_OUT_FREE:    cond_true = status.out_free;
			C_STACK_EMPTY: cond_true = status.stack_empty;
			default:       cond_true = 1'b0;
		endcase
	end

	assign ctrl.op = cw.op;
	assign ctrl.en = cw.gated ? cond_true : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= cond_true ? cw.jt : cw.jf;
		end
	end

endmodule

// ===== rtl/i2bd_dp.sv =====
// Datapath: shift-subtract divider, digit stack memory and output register.
`timescale 1ns / 1ps

module i2bd_dp #(
	parameter int VALUE_BITS = i2bd_pkg::VALUE_BITS_DEF,
	parameter int BASE_BITS  = i2bd_pkg::BASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2bd_pkg::ctrl_t       ctrl,
	input  logic [BASE_BITS-1:0]  in_base,
	input  logic [VALUE_BITS-1:0] in_value,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [BASE_BITS-1:0]  out_digit,
	output logic                  out_last,
	output logic                  out_bad,
	output i2bd_pkg::status_t     status
);
	import i2bd_pkg::*;

	localparam int SW = $clog2(VALUE_BITS + 1);
	localparam int AW = $clog2(VALUE_BITS);
	localparam int IW = $clog2(VALUE_BITS);

	logic [BASE_BITS-1:0]  base_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [BASE_BITS-1:0]  rem_q;
	logic [SW-1:0]         cnt_q;
	logic [SW-1:0]         nbits_q;
	logic [SW-1:0]         sp_q;
	logic [BASE_BITS-1:0]  rd_q;
	logic                  out_valid_q;
	logic [BASE_BITS-1:0]  out_digit_q;
	logic                  out_last_q;
	logic                  out_bad_q;

	logic [BASE_BITS-1:0]  stack_mem [VALUE_BITS];

	logic do_load, do_init, do_step, do_push, do_read, do_emit_d, do_emit_k;
	logic [IW-1:0]         idx;
	logic [BASE_BITS:0]    trial;
	logic [BASE_BITS:0]    diff;
	logic                  ge;
	logic [BASE_BITS-1:0]  rem_n;
	logic [AW-1:0]         rd_addr;
	logic                  bad_base;

	always_comb begin
		do_load   = 1'b0;
		do_init   = 1'b0;
		do_step   = 1'b0;
		do_push   = 1'b0;
		do_read   = 1'b0;
		do_emit_d = 1'b0;
		do_emit_k = 1'b0;
		unique case (ctrl.op)
			OP_NONE:       ;
			OP_LOAD:       do_load   = ctrl.en;
			OP_DIV_INIT:   do_init   = ctrl.en;
			OP_DIV_STEP:   do_step   = ctrl.en;
			OP_PUSH:       do_push   = ctrl.en;
			OP_READ:       do_read   = ctrl.en;
			OP_EMIT_DIGIT: do_emit_d = ctrl.en;
			OP_EMIT_CONST: do_emit_k = ctrl.en;
			default:       ;
		endcase
	end

	// One quotient bit per step; the dividend bit is replaced in place.
	assign idx   = IW'(cnt_q - SW'(1));
	assign trial = {rem_q, quo_q[idx]};
	assign ge    = trial >= {1'b0, base_q};
	assign diff  = trial - {1'b0, base_q};
	assign rem_n = ge ? diff[BASE_BITS-1:0] : trial[BASE_BITS-1:0];

	assign rd_addr  = AW'(sp_q - SW'(1));
	assign bad_base = base_q < BASE_BITS'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			nbits_q     <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_load) begin
				nbits_q <= SW'(VALUE_BITS);
				sp_q    <= '0;
			end
			if (do_init) begin
				cnt_q <= nbits_q;
			end
			if (do_step) begin
				cnt_q <= cnt_q - SW'(1);
			end
			if (do_push) begin
				sp_q    <= sp_q + SW'(1);
				nbits_q <= nbits_q - SW'(1);
			end
			if (do_read) begin
				sp_q <= sp_q - SW'(1);
			end
			if (do_emit_d || do_emit_k) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			base_q <= in_base;
			quo_q  <= in_value;
		end
		if (do_init) begin
			rem_q <= '0;
		end
		if (do_step) begin
			rem_q      <= rem_n;
			quo_q[idx] <= ge;
		end
		if (do_emit_d) begin
			out_digit_q <= rd_q;
			out_last_q  <= (sp_q == '0);
			out_bad_q   <= 1'b0;
		end
		if (do_emit_k) begin
			out_digit_q <= '0;
			out_last_q  <= 1'b1;
			out_bad_q   <= bad_base;
		end
	end

	// Remainders are pushed least significant first and popped in reverse.
	always_ff @(posedge clk) begin
		if (do_push) begin
			stack_mem[sp_q[AW-1:0]] <= rem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			rd_q <= stack_mem[rd_addr];
		end
	end

	assign status.bad_or_zero = bad_base || (quo_q == '0);
	assign status.cnt_last    = (cnt_q == SW'(1));
	assign status.quo_zero    = (quo_q == '0);
	assign status.stack_empty = (sp_q == '0);
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_digit = out_digit_q;
	assign out_last  = out_last_q;
	assign out_bad   = out_bad_q;

`ifndef NO_ASSERTIONS
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SW'(VALUE_BITS))
		else $error("digit stack pointer out of range");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |-> (sp_q < SW'(VALUE_BITS)))
		else $error("digit stack overflow");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		do_step |-> (rem_q < base_q))
		else $error("partial remainder not below base");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(out_digit_q) && out_valid_q)
		else $error("pending result overwritten");

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_bad_q) |-> (out_last_q && (out_digit_q == '0)))
		else $error("error result not a single zero digit");
`endif

endmodule

// ===== rtl/integer_to_base_digits.sv =====
// Top level: converts a non-negative integer into its digits in a given base, MSD first.
// A zero value or a bad base gives a single result, emitted from the constant-result step.
// Otherwise the value is divided by the base repeatedly, one shift-subtract step per
// remaining dividend bit, and the digits are then popped from the stack and emitted.
// One item at a time: a new number is taken only once the previous one is finished.
// Reset (arst_n, asynchronous) returns the sequencer to idle and empties the output stage.
`timescale 1ns / 1ps

module integer_to_base_digits #(
	parameter int VALUE_BITS = i2bd_pkg::VALUE_BITS_DEF,
	parameter int BASE_BITS  = i2bd_pkg::BASE_BITS_DEF,
	localparam int IN_W  = ((BASE_BITS + VALUE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((BASE_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// Input stream: one transaction carries one number to convert.
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // base [BASE_BITS-1:0], value above it, zero pad
	// Output stream: one transaction per digit.
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // digit [BASE_BITS-1:0], zero pad
	output logic             m_tlast,   // least significant digit, or the single result for a zero value or bad base
	output logic             m_tuser    // bad_base
);
	import i2bd_pkg::*;

	ctrl_t                 ctrl;
	status_t               status;
	logic [BASE_BITS-1:0]  in_base;
	logic [VALUE_BITS-1:0] in_value;
	logic [BASE_BITS-1:0]  digit;

	// The input fields are packed base first, in the low bits.
	assign in_base  = s_tdata[BASE_BITS-1:0];
	assign in_value = s_tdata[BASE_BITS+VALUE_BITS-1:BASE_BITS];

	// The sequencer runs a short program from its control store. The idle step
	// waits for an input transaction; the program then divides the value by the
	// base repeatedly, pushing each remainder onto a stack, and finally pops the
	// stack so the digits come out most significant first. A zero value or a
	// base below two branches straight to a step that emits one constant result.
	i2bd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.ctrl     (ctrl)
	);

	// The datapath holds the shift-subtract divider, the remainder stack and
	// the output register, which lets a finished digit wait for the consumer.
	i2bd_dp #(
		.VALUE_BITS (VALUE_BITS),
		.BASE_BITS  (BASE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_base   (in_base),
		.in_value  (in_value),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_digit (digit),
		.out_last  (m_tlast),
		.out_bad   (m_tuser),
		.status    (status)
	);

	// A new number is taken only while the program sits on its load step.
	assign s_tready = (ctrl.op == OP_LOAD);
	assign m_tdata  = OUT_W'(digit);

endmodule
